// ----- rtl/lru_tag_cache_lookup_core_assert.svh -----
// Assertion macros for the LRU tag cache lookup core checker.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef LRU_TAG_CACHE_LOOKUP_CORE_ASSERT_SVH
`define LRU_TAG_CACHE_LOOKUP_CORE_ASSERT_SVH

// antecedent in this cycle implies consequent in the same cycle
`define LRUTC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lookup core check failed");

// antecedent in this cycle implies consequent in the next cycle
`define LRUTC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lookup core check failed");

`endif

// ----- rtl/lrutc_pkg.sv -----
// Shared types, constants and the stamp minimum tree for the lookup core.
// No dependencies.
package lrutc_pkg;

  localparam int unsigned FieldW = 10;
  localparam int unsigned StampW = 32;
  localparam int unsigned GrpN   = 8;
  localparam int unsigned GrpIxW = 3;

  typedef struct packed {
    logic              cmd;
    logic [FieldW-1:0] tag_column;
    logic [FieldW-1:0] tag_row;
  } lrutc_in_t;

  typedef struct packed {
    logic              hit;
    logic [2:0]        slot_index;
    logic [StampW-1:0] refill_count;
  } lrutc_out_t;

  typedef struct packed {
    logic load;
    logic evaluate;
    logic commit;
  } lrutc_cmd_t;

  localparam logic CmdLookup = 1'b0;
  localparam logic CmdClear  = 1'b1;

  // smallest stamp of eight, lowest position wins ties
  function automatic logic [GrpIxW+StampW-1:0] min_tree(
    input logic [GrpN-1:0][StampW-1:0] st_in,
    input logic [GrpN-1:0][GrpIxW-1:0] ix_in
  );
    logic [GrpN-1:0][StampW-1:0] st;
    logic [GrpN-1:0][GrpIxW-1:0] ix;
    st = st_in;
    ix = ix_in;
    for (int s = 1; s < GrpN; s = s * 2) begin
      for (int p = 0; p < GrpN; p = p + 2 * s) begin
        if (st[p+s] < st[p]) begin
          st[p] = st[p+s];
          ix[p] = ix[p+s];
        end
      end
    end
    return {ix[0], st[0]};
  endfunction

endpackage

// ----- rtl/lrutc_ctrl.sv -----
// Sequencer for the lookup core: accept, evaluate, commit.
// Depends on lrutc_pkg.
module lrutc_ctrl import lrutc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  output logic       done_o,
  output lrutc_cmd_t cmd_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StEval = 2'd1;
  localparam logic [1:0] StCommit = 2'd2;

  logic [1:0] state_q, state_d;
  logic       done_q;
  logic       accept;

  assign busy   = (state_q == StEval);
  assign accept = start && !busy;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:   if (accept) state_d = StEval;
      StEval:   state_d = StCommit;
      StCommit: state_d = accept ? StEval : StIdle;
      default:  state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == StCommit);
    end
  end

  assign cmd_o.load     = accept;
  assign cmd_o.evaluate = (state_q == StEval);
  assign cmd_o.commit   = (state_q == StCommit);
  assign done_o         = done_q;

endmodule

// ----- rtl/lrutc_dp.sv -----
// Datapath: tag entries, key compare, stamp minimum tree, counters, result word.
// Depends on lrutc_pkg; driven by lrutc_ctrl commands.
module lrutc_dp import lrutc_pkg::*; #(
  parameter int unsigned SLOTS      = 8,
  parameter int unsigned COORD_BITS = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  lrutc_cmd_t cmd_i,
  input  lrutc_in_t  item_i,
  output lrutc_out_t result_o
);

  localparam int unsigned KeyW  = (COORD_BITS < FieldW) ? COORD_BITS : FieldW;
  localparam int unsigned SlotW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned NGrp  = (SLOTS + GrpN - 1) / GrpN;
  localparam int unsigned GrpW  = (NGrp > 1) ? $clog2(NGrp) : 1;

  lrutc_in_t                 item_q;
  logic [SLOTS-1:0]          valid_q;
  logic [KeyW-1:0]           col_q   [SLOTS];
  logic [KeyW-1:0]           row_q   [SLOTS];
  logic [StampW-1:0]         stamp_q [SLOTS];
  logic [StampW-1:0]         stamp_cnt_q;
  logic [StampW-1:0]         miss_cnt_q;
  logic [SLOTS-1:0]          match_q;
  logic [NGrp-1:0][StampW-1:0] gst_q;
  logic [NGrp-1:0][GrpIxW-1:0] gix_q;
  lrutc_out_t                res_q;

  logic [KeyW-1:0]             key_col, key_row;
  logic [SLOTS-1:0]            match_d;
  logic [NGrp-1:0][StampW-1:0] gst_d;
  logic [NGrp-1:0][GrpIxW-1:0] gix_d;
  logic                        hit;
  logic [SlotW-1:0]            hit_idx, free_idx, victim, slot;
  logic                        free_any;
  logic [StampW-1:0]           stamp_next, miss_next;

  assign key_col = item_q.tag_column[KeyW-1:0];
  assign key_row = item_q.tag_row[KeyW-1:0];

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      match_d[i] = valid_q[i] && (col_q[i] == key_col) && (row_q[i] == key_row);
    end
  end

  always_comb begin
    logic [GrpN-1:0][StampW-1:0] st;
    logic [GrpN-1:0][GrpIxW-1:0] ix;
    logic [GrpIxW+StampW-1:0]    m;
    for (int g = 0; g < NGrp; g++) begin
      for (int k = 0; k < GrpN; k++) begin
        st[k] = (g * GrpN + k < SLOTS) ? stamp_q[g*GrpN+k] : '1;
        ix[k] = GrpIxW'(k);
      end
      m        = min_tree(st, ix);
      gst_d[g] = m[StampW-1:0];
      gix_d[g] = m[GrpIxW+StampW-1:StampW];
    end
  end

  always_comb begin
    logic [GrpN-1:0][StampW-1:0] st;
    logic [GrpN-1:0][GrpIxW-1:0] ix;
    logic [GrpIxW+StampW-1:0]    m;
    logic [GrpW-1:0]             gsel;
    for (int k = 0; k < GrpN; k++) begin
      st[k] = (k < NGrp) ? gst_q[k] : '1;
      ix[k] = GrpIxW'(k);
    end
    m      = min_tree(st, ix);
    gsel   = m[GrpW+StampW-1:StampW];
    victim = SlotW'(int'(gsel) * GrpN + int'(gix_q[gsel]));
  end

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (match_q[i]) hit_idx = SlotW'(i);
      if (!valid_q[i]) free_idx = SlotW'(i);
    end
  end

  assign hit        = |match_q;
  assign free_any   = ~&valid_q;
  assign slot       = hit ? hit_idx : (free_any ? free_idx : victim);
  assign stamp_next = stamp_cnt_q + StampW'(1);
  assign miss_next  = miss_cnt_q + StampW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      stamp_cnt_q <= '0;
      miss_cnt_q  <= '0;
    end else if (cmd_i.commit) begin
      if (item_q.cmd == CmdClear) begin
        valid_q     <= '0;
        stamp_cnt_q <= '0;
        miss_cnt_q  <= '0;
      end else begin
        stamp_cnt_q <= stamp_next;
        if (!hit) begin
          valid_q[slot] <= 1'b1;
          miss_cnt_q    <= miss_next;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= item_i;
    if (cmd_i.evaluate) begin
      match_q <= match_d;
      gst_q   <= gst_d;
      gix_q   <= gix_d;
    end
    if (cmd_i.commit) begin
      if (item_q.cmd == CmdClear) begin
        res_q <= '0;
      end else begin
        stamp_q[slot] <= stamp_next;
        if (!hit) begin
          col_q[slot] <= key_col;
          row_q[slot] <= key_row;
        end
        res_q.hit          <= hit;
        res_q.slot_index   <= 3'(slot);
        res_q.refill_count <= hit ? miss_cnt_q : miss_next;
      end
    end
  end

  assign result_o = res_q;

endmodule

// ----- rtl/lru_tag_cache_lookup_core.sv -----
// Fully associative tag lookup with timestamp LRU refill, SLOTS entries.
// done_o strobes once a word has passed the item register, the evaluate registers and the result register.
// Each word passes the evaluate state (key compare, stamp minimum tree) and the commit state.
// The next start is taken in the commit cycle. done_o cannot be held off.
// Reset clears valid bits, stamp and refill counters; results are zero after a clear.
module lru_tag_cache_lookup_core import lrutc_pkg::*; #(
  parameter int unsigned SLOTS      = 8,
  parameter int unsigned COORD_BITS = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  lrutc_in_t  item_i,
  output logic       done_o,
  output lrutc_out_t result_o
);

  lrutc_cmd_t cmd;

  lrutc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

  lrutc_dp #(
    .SLOTS      (SLOTS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .item_i   (item_i),
    .result_o (result_o)
  );

endmodule

// ----- rtl/lrutc_checker.sv -----
// Port-level checks on the lookup core timing and clear results, bound to the top.
// Depends on lrutc_pkg and lru_tag_cache_lookup_core_assert.svh.
`include "lru_tag_cache_lookup_core_assert.svh"

module lrutc_checker import lrutc_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input lrutc_in_t  item_i,
  input logic       done_o,
  input lrutc_out_t result_o
);

  logic acc;
  assign acc = start && !busy;

  `LRUTC_ASSERT_NEXT(a_busy_one_cycle, busy, !busy)
  `LRUTC_ASSERT_NEXT(a_accept_busy, acc, busy)
  `LRUTC_ASSERT_NEXT(a_done_spaced, done_o, !done_o)
  `LRUTC_ASSERT_NOW(a_done_after_accept,
    done_o, $past(acc, 3) && $past(rst_ni, 2) && $past(rst_ni, 1))
  `LRUTC_ASSERT_NOW(a_clear_result,
    done_o && $past(item_i.cmd == CmdClear, 3),
    !result_o.hit && (result_o.slot_index == 3'd0) && (result_o.refill_count == '0))

endmodule

bind lru_tag_cache_lookup_core lrutc_checker u_chk (.*);

// ----- dv/testbench.sv -----
// Self-checking testbench for lru_tag_cache_lookup_core: directed and random lookup/clear words.
// Holds its own LRU tag store predictor; depends on lrutc_pkg and the core RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lrutc_pkg::*;

  localparam int Slots      = 8;
  localparam int PoolSize   = 12;
  localparam int CycleLimit = 100000;

  logic       clk_i;
  logic       rst_ni;
  logic       start;
  logic       busy;
  lrutc_in_t  item_i;
  logic       done_o;
  lrutc_out_t result_o;

  lru_tag_cache_lookup_core #(.SLOTS(Slots), .COORD_BITS(FieldW)) dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .item_i   (item_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  logic [FieldW-1:0] tag_col_q [Slots];
  logic [FieldW-1:0] tag_row_q [Slots];
  logic              tag_vld_q [Slots];
  logic [StampW-1:0] tag_stamp_q [Slots];
  logic [StampW-1:0] stamp_ctr;
  logic [StampW-1:0] refill_ctr;

  lrutc_out_t expected_q[$];
  int unsigned errors;
  int unsigned cycles;
  int unsigned n_lookups;
  int unsigned n_clears;
  int unsigned n_hits;
  int unsigned n_evictions;
  bit          steady;

  logic [FieldW-1:0] pool_col [PoolSize];
  logic [FieldW-1:0] pool_row [PoolSize];

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic void clear_store();
    for (int k = 0; k < Slots; k++) begin
      tag_vld_q[k]   = 1'b0;
      tag_col_q[k]   = '0;
      tag_row_q[k]   = '0;
      tag_stamp_q[k] = '0;
    end
    stamp_ctr  = '0;
    refill_ctr = '0;
  endfunction

  function automatic int pick_victim();
    int best;
    best = 0;
    for (int k = 0; k < Slots; k++) begin
      if (!tag_vld_q[k]) return k;
      if (tag_stamp_q[k] < tag_stamp_q[best]) best = k;
    end
    n_evictions++;
    return best;
  endfunction

  function automatic lrutc_out_t predict_lookup(lrutc_in_t w);
    lrutc_out_t r;
    int slot;
    r = '0;
    if (w.cmd == CmdClear) begin
      clear_store();
      n_clears++;
      return r;
    end
    n_lookups++;
    slot = -1;
    for (int k = 0; k < Slots; k++) begin
      if (tag_vld_q[k] && tag_col_q[k] == w.tag_column && tag_row_q[k] == w.tag_row) begin
        slot = k;
        break;
      end
    end
    stamp_ctr = stamp_ctr + 1;
    if (slot >= 0) begin
      r.hit = 1'b1;
      n_hits++;
    end else begin
      slot = pick_victim();
      tag_col_q[slot] = w.tag_column;
      tag_row_q[slot] = w.tag_row;
      tag_vld_q[slot] = 1'b1;
      refill_ctr = refill_ctr + 1;
    end
    tag_stamp_q[slot] = stamp_ctr;
    r.slot_index   = 3'(slot);
    r.refill_count = refill_ctr;
    return r;
  endfunction

  function automatic void log_mismatch(string what, lrutc_out_t exp_w, lrutc_out_t act_w);
    errors++;
    if (errors <= 10)
      $display("%0t %s: exp hit=%0b slot=%0d refills=%0d, got hit=%0b slot=%0d refills=%0d",
               $realtime, what, exp_w.hit, exp_w.slot_index, exp_w.refill_count,
               act_w.hit, act_w.slot_index, act_w.refill_count);
  endfunction

  always @(posedge clk_i) begin
    lrutc_out_t exp_w;
    if (rst_ni && done_o) begin
      if (expected_q.size() == 0) begin
        log_mismatch("unexpected word", '0, result_o);
      end else begin
        exp_w = expected_q.pop_front();
        if (result_o.hit !== exp_w.hit || result_o.slot_index !== exp_w.slot_index ||
            result_o.refill_count !== exp_w.refill_count)
          log_mismatch("word mismatch", exp_w, result_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout with %0d words outstanding", expected_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_word(input lrutc_in_t w);
    int gap;
    gap = 0;
    if (!steady && $urandom_range(99) < 13) gap = $urandom_range(4, 1);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= w;
    do @(posedge clk_i); while (busy);
    expected_q.push_back(predict_lookup(w));
  endtask

  task automatic lookup(input logic [FieldW-1:0] c, input logic [FieldW-1:0] r);
    lrutc_in_t w;
    w.cmd        = CmdLookup;
    w.tag_column = c;
    w.tag_row    = r;
    send_word(w);
  endtask

  task automatic clear_all();
    lrutc_in_t w;
    w.cmd        = CmdClear;
    w.tag_column = FieldW'($urandom);
    w.tag_row    = FieldW'($urandom);
    send_word(w);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_fill_extremes();
    clear_all();
    lookup('0, '0);
    lookup('1, '1);
    lookup('0, '1);
    lookup('1, '0);
    lookup(10'h2aa, 10'h155);
    lookup(10'h155, 10'h2aa);
    lookup(10'h001, 10'h200);
    lookup(10'h200, 10'h001);
    wait_drained();
  endtask

  task automatic test_hit_refresh();
    lookup('1, '1);
    lookup('0, '0);
    lookup(10'h2aa, 10'h155);
    wait_drained();
  endtask

  task automatic test_lru_eviction();
    lookup(10'h0f0, 10'h00f);
    lookup(10'h00f, 10'h0f0);
    lookup('0, '0);
    lookup(10'h0f0, 10'h00f);
    wait_drained();
  endtask

  task automatic test_clear_reuse();
    clear_all();
    lookup('0, '0);
    lookup('0, '0);
    lookup(10'h005, 10'h005);
    clear_all();
    lookup(10'h005, 10'h005);
    wait_drained();
  endtask

  task automatic refresh_pool();
    for (int k = 0; k < PoolSize; k++) begin
      pool_col[k] = FieldW'($urandom);
      pool_row[k] = FieldW'($urandom);
    end
  endtask

  task automatic test_random_traffic(input int n_words);
    int p;
    refresh_pool();
    for (int i = 0; i < n_words; i++) begin
      steady = (i >= n_words / 3) && (i < n_words / 3 + 120);
      if (i == n_words / 2) wait_drained();
      if ($urandom_range(99) < 3) begin
        clear_all();
        refresh_pool();
      end else if ($urandom_range(99) < 80) begin
        p = $urandom_range(PoolSize - 1);
        lookup(pool_col[p], pool_row[p]);
      end else begin
        lookup(FieldW'($urandom), FieldW'($urandom));
      end
    end
    steady = 1'b0;
    wait_drained();
  endtask

  initial begin
    errors      = 0;
    cycles      = 0;
    n_lookups   = 0;
    n_clears    = 0;
    n_hits      = 0;
    n_evictions = 0;
    steady      = 1'b0;
    clear_store();
    rst_ni = 1'b0;
    start  = 1'b0;
    item_i = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_fill_extremes();
    test_hit_refresh();
    test_lru_eviction();
    test_clear_reuse();
    test_random_traffic(450);

    repeat (6) @(posedge clk_i);
    $display("covered %0d lookups (%0d hits, %0d LRU evictions) and %0d clears",
             n_lookups, n_hits, n_evictions, n_clears);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/lrutc_pkg.sv
rtl/lrutc_ctrl.sv
rtl/lrutc_dp.sv
rtl/lru_tag_cache_lookup_core.sv
rtl/lrutc_checker.sv
dv/testbench.sv
